### hdl/srlm_pkg.sv
// Shared types and constants of the stereo RMS level meter.
`default_nettype none

package srlm_pkg;

	// Field widths of the channels and registers.
	localparam int SAMPLE_W    = 16;
	localparam int HALF_W      = 15;
	localparam int SQ_W        = 29;
	localparam int LEVEL_W     = 15;
	localparam int SCALED_W    = 16;
	localparam int FRAME_W     = 16;
	localparam int KEEP_W      = 16;
	localparam int FS_W        = 15;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	// Square root unit: a 30-bit radicand gives a 15-bit root, one bit a step.
	localparam int RAD_W       = 30;
	localparam int ROOT_W      = 15;
	localparam int ROOT_REM_W  = 18;
	localparam int ROOT_CNT_W  = 4;

	// Smoothing multiplier and sum.
	localparam int MUL_A_W     = 17;
	localparam int MUL_B_W     = 16;
	localparam int PROD_W      = 33;
	localparam int ACC_W       = 34;
	localparam int ROUND_BIT   = 16;

	// Dividend width of the scaling divide: a level shifted up by 16 bits.
	localparam int SCALE_NUM_W = 31;

	localparam logic [KEEP_W-1:0]    KEEP_RESET    = 16'd60948;
	localparam logic [FS_W-1:0]      FS_RESET      = 15'd5571;
	localparam logic [LEVEL_W-1:0]   LEVEL_MAX     = 15'h7FFF;
	localparam logic [SCALED_W-1:0]  SCALED_MAX    = 16'hFFFF;
	localparam logic [MUL_A_W-1:0]   KEEP_ONE      = 17'h10000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_KEEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_MEAN_LOAD,
		ST_MEAN_DIV,
		ST_ROOT_LOAD,
		ST_ROOT,
		ST_MUL_OLD,
		ST_MUL_RMS,
		ST_SMOOTH,
		ST_SCALE_LOAD,
		ST_SCALE_DIV,
		ST_OUTPUT
	} srlm_state_t;

	typedef struct packed {
		logic accept;
		logic mean_load;
		logic root_load;
		logic mul_old;
		logic mul_rms;
		logic smooth;
		logic scale_load;
		logic out_load;
	} srlm_cmd_t;

	typedef struct packed {
		logic div_done;
		logic root_done;
		logic out_free;
	} srlm_sts_t;

endpackage

`default_nettype wire

### hdl/srlm_in_if.sv
// Sample pair channel: valid, ready and one stereo pair.
`default_nettype none

interface srlm_in_if
	import srlm_pkg::*;
	();

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       last_in_frame;

	modport source (
		output valid, left_sample, right_sample, last_in_frame,
		input  ready
	);

	modport sink (
		input  valid, left_sample, right_sample, last_in_frame,
		output ready
	);

endinterface

`default_nettype wire

### hdl/srlm_out_if.sv
// Level result channel: valid, ready and one set of frame levels.
`default_nettype none

interface srlm_out_if
	import srlm_pkg::*;
	();

	logic                valid;
	logic                ready;
	logic [LEVEL_W-1:0]  rms_level;
	logic [LEVEL_W-1:0]  smoothed_level;
	logic [SCALED_W-1:0] scaled_level;
	logic [FRAME_W-1:0]  frame_number;

	modport source (
		output valid, rms_level, smoothed_level, scaled_level, frame_number,
		input  ready
	);

	modport sink (
		input  valid, rms_level, smoothed_level, scaled_level, frame_number,
		output ready
	);

endinterface

`default_nettype wire

### hdl/srlm_ctrl.sv
// Frame sequencer of the level meter.
`default_nettype none

module srlm_ctrl
	import srlm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_last,
	input  wire srlm_sts_t sts,
	output logic           in_ready,
	output srlm_cmd_t      cmd
);

	srlm_state_t state_q;
	srlm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_last) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				state_d = ST_MEAN_LOAD;
			end
			ST_MEAN_LOAD: begin
				cmd.mean_load = 1'b1;
				state_d       = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				if (sts.div_done) begin
					state_d = ST_ROOT_LOAD;
				end
			end
			ST_ROOT_LOAD: begin
				cmd.root_load = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				if (sts.root_done) begin
					state_d = ST_MUL_OLD;
				end
			end
			ST_MUL_OLD: begin
				cmd.mul_old = 1'b1;
				state_d     = ST_MUL_RMS;
			end
			ST_MUL_RMS: begin
				cmd.mul_rms = 1'b1;
				state_d     = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = ST_SCALE_LOAD;
			end
			ST_SCALE_LOAD: begin
				cmd.scale_load = 1'b1;
				state_d        = ST_SCALE_DIV;
			end
			ST_SCALE_DIV: begin
				if (sts.div_done) begin
					state_d = ST_OUTPUT;
				end
			end
			ST_OUTPUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/srlm_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module srlm_div #(
	parameter int DIVIDEND_W = 40,
	parameter int DIVISOR_W  = 15
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic      [DIVIDEND_W-1:0] quotient,
	output logic                       done
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_diff;
	logic                  fits;

	// The remainder stays below the divisor, so its top bit is free for the shift.
	assign rem_sh   = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
	assign fits     = (rem_sh >= {1'b0, dvs_q});
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign done     = (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_W'(DIVIDEND_W);
		end else if (!done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (!done) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? rem_diff : rem_sh;
		end
	end

endmodule

`default_nettype wire

### hdl/srlm_dp.sv
// Datapath of the level meter: accumulation, root, smoothing, scaling, output.
`default_nettype none

module srlm_dp
	import srlm_pkg::*;
#(
	parameter int MAX_FRAME_PAIRS = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic signed [SAMPLE_W-1:0] left_sample,
	input  wire logic signed [SAMPLE_W-1:0] right_sample,
	input  wire srlm_cmd_t                  cmd,
	input  wire logic                       out_ready,
	output srlm_sts_t                       sts,
	output logic                            out_valid,
	output logic [LEVEL_W-1:0]              rms_level,
	output logic [LEVEL_W-1:0]              smoothed_level,
	output logic [SCALED_W-1:0]             scaled_level,
	output logic [FRAME_W-1:0]              frame_number
);

	localparam int CNT_W = $clog2(2 * MAX_FRAME_PAIRS + 1);
	localparam int SUM_W = $clog2(MAX_FRAME_PAIRS) + SQ_W + 1;
	localparam int DIV_W = (SUM_W > SCALE_NUM_W) ? SUM_W : SCALE_NUM_W;
	localparam int DVS_W = (CNT_W > FS_W) ? CNT_W : FS_W;
	localparam logic [CNT_W-1:0] SAMPLE_LIMIT = CNT_W'(2 * MAX_FRAME_PAIRS);

	// Configuration registers.
	logic [KEEP_W-1:0] keep_q;
	logic [FS_W-1:0]   fs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
			fs_q   <= FS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SMOOTH_KEEP) begin
				keep_q <= cfg_data;
			end else begin
				fs_q <= cfg_data[FS_W-1:0];
			end
		end
	end

	// Square stage: halve each sample, square it, register both squares.
	logic signed [HALF_W-1:0]   half_l;
	logic signed [HALF_W-1:0]   half_r;
	logic signed [2*HALF_W-1:0] prod_l;
	logic signed [2*HALF_W-1:0] prod_r;
	logic [SQ_W-1:0]            sq_l_s1;
	logic [SQ_W-1:0]            sq_r_s1;
	logic                       sq_vld_s1;
	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           count_q;
	logic                       take;

	assign half_l = left_sample[SAMPLE_W-1:1];
	assign half_r = right_sample[SAMPLE_W-1:1];
	assign prod_l = half_l * half_l;
	assign prod_r = half_r * half_r;
	assign take   = cmd.accept && (count_q < SAMPLE_LIMIT);

	always_ff @(posedge clk) begin
		if (take) begin
			sq_l_s1 <= prod_l[SQ_W-1:0];
			sq_r_s1 <= prod_r[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s1 <= 1'b0;
			sum_q     <= '0;
			count_q   <= '0;
		end else begin
			sq_vld_s1 <= take;
			if (cmd.out_load) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				if (sq_vld_s1) begin
					sum_q <= sum_q + SUM_W'(sq_l_s1) + SUM_W'(sq_r_s1);
				end
				if (take) begin
					count_q <= count_q + CNT_W'(2);
				end
			end
		end
	end

	// Shared divider: mean square first, then the scaled level.
	logic [LEVEL_W-1:0] smooth_q;
	logic               div_load;
	logic [DIV_W-1:0]   div_num;
	logic [DVS_W-1:0]   div_den;
	logic [DIV_W-1:0]   div_quo;
	logic               div_done;

	assign div_load = cmd.mean_load || cmd.scale_load;
	assign div_num  = cmd.mean_load ? DIV_W'(sum_q)
	                                : DIV_W'({smooth_q, 16'h0000});
	assign div_den  = cmd.mean_load ? DVS_W'(count_q) : DVS_W'(fs_q);

	srlm_div #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Square root, two radicand bits per cycle. The mean is at most 2^28.
	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_REM_W-1:0] rrem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_CNT_W-1:0] rcnt_q;
	logic [ROOT_REM_W-1:0] rrem_sh;
	logic [ROOT_REM_W-1:0] rtrial;
	logic                  rfits;
	logic                  root_done;

	assign rrem_sh   = {rrem_q[ROOT_REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign rtrial    = {1'b0, root_q, 2'b01};
	assign rfits     = (rrem_sh >= rtrial);
	assign root_done = (rcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (cmd.root_load) begin
			rcnt_q <= ROOT_CNT_W'(ROOT_W);
		end else if (!root_done) begin
			rcnt_q <= rcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rad_q  <= div_quo[RAD_W-1:0];
			rrem_q <= '0;
			root_q <= '0;
		end else if (!root_done) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rrem_q <= rfits ? (rrem_sh - rtrial) : rrem_sh;
			root_q <= {root_q[ROOT_W-2:0], rfits};
		end
	end

	// Smoothing: one shared multiplier, keep*old then (1-keep)*rms.
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  prod_old_q;
	logic [ACC_W-1:0]   acc;
	logic [ACC_W-ROUND_BIT-1:0] acc_hi;
	logic [LEVEL_W-1:0] smooth_next;

	assign mul_a = cmd.mul_rms ? (KEEP_ONE - MUL_A_W'(keep_q)) : MUL_A_W'(keep_q);
	assign mul_b = cmd.mul_rms ? MUL_B_W'(root_q) : MUL_B_W'(smooth_q);
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_old || cmd.mul_rms) begin
			prod_q <= mul_p;
		end
		if (cmd.mul_rms) begin
			prod_old_q <= prod_q;
		end
	end

	assign acc    = ACC_W'(prod_old_q) + ACC_W'(prod_q) + (ACC_W'(1) << (ROUND_BIT - 1));
	assign acc_hi = acc[ACC_W-1:ROUND_BIT];
	assign smooth_next = (acc_hi > (ACC_W-ROUND_BIT)'(LEVEL_MAX)) ? LEVEL_MAX
	                                                              : acc_hi[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
		end else if (cmd.smooth) begin
			smooth_q <= smooth_next;
		end
	end

	// Scaled level, saturated; a zero full scale maps any nonzero level to the top.
	logic [SCALED_W-1:0] scaled_next;

	always_comb begin
		if (fs_q == '0) begin
			scaled_next = (smooth_q == '0) ? '0 : SCALED_MAX;
		end else if (|div_quo[DIV_W-1:SCALED_W]) begin
			scaled_next = SCALED_MAX;
		end else begin
			scaled_next = div_quo[SCALED_W-1:0];
		end
	end

	// Result register and frame counter.
	logic [FRAME_W-1:0] frames_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			frames_q    <= frames_q + 1'b1;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rms_level      <= root_q;
			smoothed_level <= smooth_q;
			scaled_level   <= scaled_next;
			frame_number   <= frames_q + 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.div_done  = div_done;
	assign sts.root_done = root_done;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

`default_nettype wire

### hdl/stereo_rms_level_meter.sv
// Top level of the stereo RMS level meter: sequencer and datapath.
//
// Usage: stereo sample pairs (Q1.15) come in on the samples channel, one item
// per valid/ready handshake. A pair without last_in_frame is taken while the
// sequencer is idle; its halved squares are registered and added to the frame
// sum in the following cycle. Once a frame holds MAX_FRAME_PAIRS pairs,
// further pairs are taken but not summed. The pair with last_in_frame set
// closes the frame: the sequencer runs the mean divide and the scaling divide
// on one shared bit-serial divider, W bits wide with W = 40 at the default
// and W = max(31, log2(MAX_FRAME_PAIRS) + 30), and a 15-step square root.
// The result item then goes to the output register; no pair is taken before.
// The levels channel carries rms_level, smoothed_level, scaled_level and
// frame_number. The output register lets the next frame accumulate while a
// result waits; if the receiver still holds the previous result when the next
// one is ready, the sequencer waits in its output step until it is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at once.
// Reset clears the sums, the smoothed level and the frame count, and restores
// the default smoothing weight and full scale.
`default_nettype none

module stereo_rms_level_meter
	import srlm_pkg::*;
#(
	parameter int MAX_FRAME_PAIRS = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	srlm_in_if.sink                    samples,
	srlm_out_if.source                 levels,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	srlm_cmd_t cmd;
	srlm_sts_t sts;
	logic      in_ready;

	assign samples.ready = in_ready;

	// The sequencer only sees handshake state and unit status.
	srlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_last  (samples.last_in_frame),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	srlm_dp #(
		.MAX_FRAME_PAIRS (MAX_FRAME_PAIRS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.left_sample    (samples.left_sample),
		.right_sample   (samples.right_sample),
		.cmd            (cmd),
		.out_ready      (levels.ready),
		.sts            (sts),
		.out_valid      (levels.valid),
		.rms_level      (levels.rms_level),
		.smoothed_level (levels.smoothed_level),
		.scaled_level   (levels.scaled_level),
		.frame_number   (levels.frame_number)
	);

endmodule

`default_nettype wire
